// ----- sv/dq_pkg.sv -----
// ---------------------------------------------------------------------------
// dq_pkg: shared types for the double-ended queue
// Request and result words, action and status codes, cell operations.
// ---------------------------------------------------------------------------
package dq_pkg;

  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_DUMP_FWD   = 3'd2,
    ACT_DUMP_BWD   = 3'd3,
    ACT_POP_FRONT  = 3'd4,
    ACT_POP_BACK   = 3'd5
  } act_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } dq_state_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH_FRONT,
    CELL_PUSH_BACK,
    CELL_POP_FRONT,
    CELL_POP_BACK,
    CELL_ROT_FWD,
    CELL_ROT_BWD
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
  } cell_ctrl_t;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] item_in;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] item_out;
    logic               last_item;
  } res_t;

endpackage

// ----- sv/dq_cell.sv -----
// ---------------------------------------------------------------------------
// dq_cell: one position of the deque
// Holds a word and a valid flag; moves data to or from its neighbours.
// ---------------------------------------------------------------------------
module dq_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dq_pkg::cell_ctrl_t     ctrl_i,
  input  logic [DATA_WIDTH-1:0]  push_word_i,
  input  logic [DATA_WIDTH-1:0]  head_word_i,
  input  logic [DATA_WIDTH-1:0]  prev_word_i,
  input  logic                   prev_valid_i,
  input  logic [DATA_WIDTH-1:0]  next_word_i,
  input  logic                   next_valid_i,
  output logic [DATA_WIDTH-1:0]  word_o,
  output logic                   valid_o
);
  import dq_pkg::*;

  logic [DATA_WIDTH-1:0] word_q, word_d;
  logic                  valid_q, valid_d;
  logic                  is_tail;

  // last occupied position of the row
  assign is_tail = valid_q && !next_valid_i;

  always_comb begin
    word_d  = word_q;
    valid_d = valid_q;
    case (ctrl_i.op)
      CELL_PUSH_FRONT: begin
        word_d  = prev_word_i;
        valid_d = prev_valid_i;
      end
      CELL_PUSH_BACK: begin
        if (!valid_q && prev_valid_i) begin
          word_d  = push_word_i;
          valid_d = 1'b1;
        end
      end
      CELL_POP_FRONT: begin
        word_d  = next_word_i;
        valid_d = next_valid_i;
      end
      CELL_POP_BACK: begin
        if (is_tail) valid_d = 1'b0;
      end
      CELL_ROT_FWD: begin
        if (is_tail) word_d = head_word_i;
        else if (valid_q) word_d = next_word_i;
      end
      CELL_ROT_BWD: begin
        if (valid_q) word_d = prev_word_i;
      end
      default: begin
        word_d  = word_q;
        valid_d = valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o  = word_q;
  assign valid_o = valid_q;

endmodule

// ----- sv/double_ended_queue_top.sv -----
// ---------------------------------------------------------------------------
// double_ended_queue_top: double-ended queue as a row of cells
// Push, pop and dump at either end of a DEPTH-word deque.
// ---------------------------------------------------------------------------
// Usage:
//   A request (action, item_in) is taken on a clock edge with start_i high
//   and busy_o low. Results appear on res_o for one cycle, flagged by
//   res_valid_o; the receiver must take them as they come.
//   Push and pop: one result, in the cycle after the request; a new request
//   may follow in the very next cycle. A full push or empty pop answers
//   with status full or empty and leaves the contents alone.
//   Dump: one word per cycle, one for each stored word, the first after the
//   state has entered dump and the word has passed the result register,
//   last_item on the final word. busy_o stays high while the row of cells
//   rotates once through its occupied span, and the next request is taken
//   once busy_o is low again. An empty dump answers with a single empty
//   result, in the cycle after the request.
//   Front of the deque is always cell 0; data shifts one cell per cycle.
//   Unused action codes are dropped without a result.
//   Reset empties the deque and clears any pending result strobe.
// ---------------------------------------------------------------------------
module double_ended_queue_top #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  dq_pkg::req_t  req_i,
  output logic          res_valid_o,
  output dq_pkg::res_t  res_o
);
  import dq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  dq_state_e        state_q, state_d;
  logic [CNT_W-1:0] occ_q, occ_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             bwd_q, bwd_d;
  logic             res_valid_q, res_valid_d;
  res_t             res_q, res_d;

  cell_ctrl_t            cell_ctrl;
  logic                  accept;
  logic [DATA_WIDTH-1:0] push_word;
  logic [DATA_WIDTH-1:0] edge_word;
  logic [DATA_WIDTH-1:0] tail_word;
  logic [DATA_WIDTH-1:0] head_word;
  logic [DATA_WIDTH-1:0] out_word;

  logic [DATA_WIDTH-1:0] cell_word  [DEPTH];
  logic                  cell_valid [DEPTH];
  logic [DATA_WIDTH-1:0] prev_word  [DEPTH];
  logic                  prev_valid [DEPTH];
  logic [DATA_WIDTH-1:0] next_word  [DEPTH];
  logic                  next_valid [DEPTH];

  assign busy_o    = (state_q == S_DUMP);
  assign accept    = start_i && !busy_o;
  assign push_word = DATA_WIDTH'(req_i.item_in);
  assign head_word = cell_word[0];
  // backward rotation feeds the tail word into cell 0
  assign edge_word = (cell_ctrl.op == CELL_ROT_BWD) ? tail_word : push_word;

  // one-hot pick of the last occupied cell
  always_comb begin
    tail_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_word = tail_word |
                  ({DATA_WIDTH{cell_valid[i] && !next_valid[i]}} & cell_word[i]);
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign prev_word[g]  = edge_word;
      assign prev_valid[g] = 1'b1;
    end else begin : g_body
      assign prev_word[g]  = cell_word[g-1];
      assign prev_valid[g] = cell_valid[g-1];
    end
    if (g == DEPTH - 1) begin : g_end
      assign next_word[g]  = '0;
      assign next_valid[g] = 1'b0;
    end else begin : g_mid
      assign next_word[g]  = cell_word[g+1];
      assign next_valid[g] = cell_valid[g+1];
    end

    dq_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl),
      .push_word_i  (push_word),
      .head_word_i  (head_word),
      .prev_word_i  (prev_word[g]),
      .prev_valid_i (prev_valid[g]),
      .next_word_i  (next_word[g]),
      .next_valid_i (next_valid[g]),
      .word_o       (cell_word[g]),
      .valid_o      (cell_valid[g])
    );
  end

  assign out_word = bwd_q ? tail_word : head_word;

  always_comb begin
    state_d           = state_q;
    occ_d             = occ_q;
    cnt_d             = cnt_q;
    bwd_d             = bwd_q;
    cell_ctrl.op      = CELL_HOLD;
    res_valid_d       = 1'b0;
    res_d             = res_q;
    res_d.status      = ST_OK;
    res_d.item_out    = '0;
    res_d.last_item   = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (act_e'(req_i.action))
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
              res_valid_d = 1'b1;
              if (occ_q == CNT_W'(DEPTH)) begin
                res_d.status = ST_FULL;
              end else begin
                cell_ctrl.op = (act_e'(req_i.action) == ACT_PUSH_FRONT) ?
                               CELL_PUSH_FRONT : CELL_PUSH_BACK;
                occ_d = occ_q + CNT_W'(1);
              end
            end
            ACT_DUMP_FWD, ACT_DUMP_BWD: begin
              if (occ_q == '0) begin
                res_valid_d  = 1'b1;
                res_d.status = ST_EMPTY;
              end else begin
                state_d = S_DUMP;
                cnt_d   = occ_q;
                bwd_d   = (act_e'(req_i.action) == ACT_DUMP_BWD);
              end
            end
            ACT_POP_FRONT, ACT_POP_BACK: begin
              res_valid_d = 1'b1;
              if (occ_q == '0) begin
                res_d.status = ST_EMPTY;
              end else begin
                cell_ctrl.op = (act_e'(req_i.action) == ACT_POP_FRONT) ?
                               CELL_POP_FRONT : CELL_POP_BACK;
                occ_d = occ_q - CNT_W'(1);
              end
            end
            default: begin
              res_valid_d = 1'b0;
            end
          endcase
        end
      end
      S_DUMP: begin
        // emit the end word and rotate it round to the far end
        cell_ctrl.op    = bwd_q ? CELL_ROT_BWD : CELL_ROT_FWD;
        res_valid_d     = 1'b1;
        res_d.item_out  = 32'(signed'(out_word));
        res_d.last_item = (cnt_q == CNT_W'(1));
        cnt_d           = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      cnt_q       <= '0;
      bwd_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      cnt_q       <= cnt_d;
      bwd_q       <= bwd_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
